/* rtl/tlbsc_pkg.sv */
// tlbsc_pkg: types and fixed constants shared by the second-chance TLB modules.
// No dependencies.
`default_nettype none
package tlbsc_pkg;

    localparam int PAGE_FIELD_W   = 20;
    localparam int OFFSET_FIELD_W = 16;
    localparam int FRAME_FIELD_W  = 20;
    localparam int PHYS_W         = 36;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 64;

    localparam int LOG_ENTRIES_W  = 3;
    localparam int OFFSET_BITS_W  = 5;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 5;
    localparam int OFFSET_CLAMP   = 16;

    localparam logic [LOG_ENTRIES_W-1:0] LOG_ENTRIES_RESET = 3'd4;
    localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RESET = 5'd12;

    localparam logic [CFG_INDEX_W-1:0] REG_LOG_ENTRIES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

/* rtl/tlb_second_chance.sv */
// tlb_second_chance: fully associative TLB with second-chance replacement.
// Depends on tlbsc_pkg, tlbsc_ctrl, tlbsc_dp (and tlbsc_ram below it).
//
// Usage: one beat on s_ is one access; the block returns exactly one beat on m_.
// A lookup compares every in-use tag in parallel; a miss fills the lowest
// invalid entry, or sweeps from entry 0 clearing used bits and takes the first
// unused entry (entry 0 when all were used).
// Sequence: ST_LOOKUP compares the tags and reads the frame RAM, then ST_FINISH
// registers the result; a new access is taken only as the last one finishes.
// s_tready is high while idle and in the cycle a result is registered, so the
// next access may follow directly.
// Stall: if m_tready stays low with a result held, the next result waits in
// its finish cycle and s_tready stays low until the output register frees.
// Reset: all entries invalid, log_entries_used = 4, offset_bits = 12; no
// clearing pass, s_tready is low while aresetn is low and the block accepts
// beats straight after reset.
// Configuration: cfg_ready is always high; write only while the block is idle.
`default_nettype none
module tlb_second_chance #(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // [19:0] virt_page, [35:20] page_offset, [55:36] walk_frame
    input  wire [tlbsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [0] kind
    input  wire [0:0]                            s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [35:0] phys_addr, [36] hit, [37] evicted, [57:38] victim_page,
    // [58] victim_dirty, [59] page_dirty_mark, [63:60] zero
    output logic [tlbsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [tlbsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [tlbsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tlbsc_pkg::cmd_t  cmd;
    tlbsc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tlbsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlbsc_dp #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (s_tuser[0]),
        .in_page   (s_tdata[19:0]),
        .in_offset (s_tdata[35:20]),
        .in_frame  (s_tdata[55:36]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

/* rtl/tlbsc_ram.sv */
// tlbsc_ram: generic single-port-write, single-port-read RAM, registered read,
// read-first on a same-address write. No dependencies.
`default_nettype none
module tlbsc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire                                      aclk,
    input  wire                                      wr_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                          wr_data,
    input  wire                                      rd_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/tlbsc_ctrl.sv */
// tlbsc_ctrl: sequencing state machine for one access at a time.
// Depends on tlbsc_pkg.
`default_nettype none
module tlbsc_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  tlbsc_pkg::stat_t    stat,
    output tlbsc_pkg::cmd_t     cmd
);

    tlbsc_pkg::state_t state_reg;
    tlbsc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlbsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlbsc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tlbsc_pkg::ST_LOOKUP;
                end
            end
            tlbsc_pkg::ST_LOOKUP: begin
                state_next = tlbsc_pkg::ST_FINISH;
            end
            tlbsc_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = s_tvalid ? tlbsc_pkg::ST_LOOKUP : tlbsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlbsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            tlbsc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            tlbsc_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            tlbsc_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.load    = 1'b1;
                    s_tready    = 1'b1;
                    cmd.capture = s_tvalid;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        // no beat is taken while held in reset
        if (!aresetn) begin
            s_tready    = 1'b0;
            cmd.capture = 1'b0;
        end
    end

    // a new beat is only taken while nothing is in flight or the result is leaving
    a_capture_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (state_reg == tlbsc_pkg::ST_IDLE) || cmd.load)
        else $error("capture while an access is in flight");

    a_lookup_then_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |=> state_reg == tlbsc_pkg::ST_FINISH)
        else $error("lookup not followed by finish");

    a_capture_then_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.lookup)
        else $error("captured beat not looked up");

endmodule
`default_nettype wire

/* rtl/tlbsc_dp.sv */
// tlbsc_dp: tag cells, used/dirty/valid bits, victim search, frame RAM, output register.
// Depends on tlbsc_pkg and tlbsc_ram.
`default_nettype none
module tlbsc_dp #(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  tlbsc_pkg::cmd_t                       cmd,
    output tlbsc_pkg::stat_t                      stat,
    input  wire                                   in_kind,
    input  wire [tlbsc_pkg::PAGE_FIELD_W-1:0]     in_page,
    input  wire [tlbsc_pkg::OFFSET_FIELD_W-1:0]   in_offset,
    input  wire [tlbsc_pkg::FRAME_FIELD_W-1:0]    in_frame,
    input  wire                                   cfg_valid,
    input  wire [tlbsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [tlbsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [tlbsc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int TAG_W = (PAGE_BITS < tlbsc_pkg::PAGE_FIELD_W) ? PAGE_BITS
                                                                 : tlbsc_pkg::PAGE_FIELD_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    // configuration
    logic [tlbsc_pkg::LOG_ENTRIES_W-1:0] log_entries_reg;
    logic [tlbsc_pkg::OFFSET_BITS_W-1:0] offset_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_entries_reg <= tlbsc_pkg::LOG_ENTRIES_RESET;
            offset_bits_reg <= tlbsc_pkg::OFFSET_BITS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tlbsc_pkg::REG_LOG_ENTRIES:
                    log_entries_reg <= cfg_data[tlbsc_pkg::LOG_ENTRIES_W-1:0];
                tlbsc_pkg::REG_OFFSET_BITS:
                    offset_bits_reg <= cfg_data[tlbsc_pkg::OFFSET_BITS_W-1:0];
                default: begin
                    log_entries_reg <= log_entries_reg;
                end
            endcase
        end
    end

    // captured access
    logic                                 kind_reg;
    logic [TAG_W-1:0]                     page_reg;
    logic [tlbsc_pkg::OFFSET_FIELD_W-1:0] offset_reg;
    logic [TAG_W-1:0]                     walk_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= in_kind;
            page_reg   <= in_page[TAG_W-1:0];
            offset_reg <= in_offset;
            walk_reg   <= in_frame[TAG_W-1:0];
        end
    end

    // entry state
    logic [ENTRIES-1:0] entry_valid_reg;
    logic [ENTRIES-1:0] entry_used_reg;
    logic [ENTRIES-1:0] entry_dirty_reg;
    logic [TAG_W-1:0]   entry_page_reg [ENTRIES];

    logic [ENTRIES-1:0] active;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] hit_oh;
    logic [ENTRIES-1:0] invalid;
    logic [ENTRIES-1:0] inv_oh;
    logic [ENTRIES-1:0] not_used;
    logic [ENTRIES-1:0] nu_oh;
    logic [ENTRIES-1:0] swept;
    logic [ENTRIES-1:0] slot_oh;
    logic [ENTRIES-1:0] touch_oh;
    logic [IDX_W-1:0]   touch_idx;
    logic               hit;
    logic               any_inv;
    logic               any_nu;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            active[i]   = ((CNT_W'(i) >> log_entries_reg) == '0);
            match[i]    = entry_valid_reg[i] && active[i] && (entry_page_reg[i] == page_reg);
            invalid[i]  = !entry_valid_reg[i] && active[i];
            not_used[i] = !entry_used_reg[i] && active[i];
        end
        hit      = |match;
        any_inv  = |invalid;
        any_nu   = |not_used;
        hit_oh   = match & (~match + 1'b1);
        inv_oh   = invalid & (~invalid + 1'b1);
        nu_oh    = not_used & (~not_used + 1'b1);
        // entries passed over by the sweep; all active ones when every entry was used
        swept    = (nu_oh - 1'b1) & active;
        if (any_inv) begin
            slot_oh = inv_oh;
        end else if (any_nu) begin
            slot_oh = nu_oh;
        end else begin
            slot_oh = ENTRIES'(1);
        end
        touch_oh  = hit ? hit_oh : slot_oh;
        touch_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (touch_oh[i]) begin
                touch_idx = touch_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            entry_used_reg  <= '0;
            entry_dirty_reg <= '0;
        end else if (cmd.lookup) begin
            if (hit) begin
                entry_used_reg  <= entry_used_reg | hit_oh;
                entry_dirty_reg <= entry_dirty_reg | (kind_reg ? hit_oh : '0);
            end else begin
                entry_valid_reg <= entry_valid_reg | slot_oh;
                entry_used_reg  <= (entry_used_reg & ~(any_inv ? '0 : swept)) | slot_oh;
                entry_dirty_reg <= (entry_dirty_reg & ~slot_oh) | (kind_reg ? slot_oh : '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (cmd.lookup && !hit && slot_oh[i]) begin
                entry_page_reg[i] <= page_reg;
            end
        end
    end

    // lookup outcome
    logic hit_q_reg;
    logic evict_q_reg;
    logic vdirty_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_q_reg    <= hit;
            evict_q_reg  <= !hit && !any_inv;
            vdirty_q_reg <= !hit && !any_inv && |(entry_dirty_reg & slot_oh);
        end
    end

    // page and frame per entry; read-first gives the victim's page on a fill
    logic [2*TAG_W-1:0] ram_rd_data;

    tlbsc_ram #(
        .WIDTH (2 * TAG_W),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (cmd.lookup && !hit),
        .wr_addr (touch_idx),
        .wr_data ({page_reg, walk_reg}),
        .rd_en   (cmd.lookup),
        .rd_addr (touch_idx),
        .rd_data (ram_rd_data)
    );

    // result assembly
    logic [tlbsc_pkg::OFFSET_BITS_W-1:0]  ob;
    logic [tlbsc_pkg::OFFSET_FIELD_W:0]   off_mask;
    logic [tlbsc_pkg::FRAME_FIELD_W-1:0]  frame;
    logic [tlbsc_pkg::PAGE_FIELD_W-1:0]   victim_page;
    logic [tlbsc_pkg::PHYS_W-1:0]         phys_addr;
    logic [tlbsc_pkg::OUT_TDATA_W-1:0]    out_word;

    always_comb begin
        ob = (offset_bits_reg > tlbsc_pkg::OFFSET_BITS_W'(tlbsc_pkg::OFFSET_CLAMP))
           ? tlbsc_pkg::OFFSET_BITS_W'(tlbsc_pkg::OFFSET_CLAMP) : offset_bits_reg;
        off_mask = ((tlbsc_pkg::OFFSET_FIELD_W+1)'(1) << ob) - 1'b1;
        frame = tlbsc_pkg::FRAME_FIELD_W'(hit_q_reg ? ram_rd_data[TAG_W-1:0] : walk_reg);
        victim_page = evict_q_reg
                    ? tlbsc_pkg::PAGE_FIELD_W'(ram_rd_data[2*TAG_W-1:TAG_W]) : '0;
        phys_addr = (tlbsc_pkg::PHYS_W'(frame) << ob)
                  | tlbsc_pkg::PHYS_W'(offset_reg & off_mask[tlbsc_pkg::OFFSET_FIELD_W-1:0]);
        out_word = tlbsc_pkg::OUT_TDATA_W'({kind_reg, vdirty_q_reg, victim_page,
                                            evict_q_reg, hit_q_reg, phys_addr});
    end

    logic                              m_tvalid_reg;
    logic [tlbsc_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    // a valid entry stays valid until reset
    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((entry_valid_reg & $past(entry_valid_reg))
                            == $past(entry_valid_reg)))
        else $error("valid entry lost");

    a_touch_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |-> $onehot(touch_oh))
        else $error("lookup did not select exactly one entry");

    a_touch_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |=> (|(entry_used_reg & entry_valid_reg & $past(touch_oh))))
        else $error("accessed entry not left valid and used");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire
